FILE: rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

  // Request codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  // Command broadcast to every cell of the segment queue.
  typedef struct packed {
    logic pop;   // every cell takes its right-hand neighbour's entry, unless it takes the push
    logic push;  // the cell at the write position takes the pushed entry
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/ffha_cell.sv
`default_nettype none
module ffha_cell #(
  parameter int INDEX     = 0,
  parameter int AW        = 20,
  parameter int CW        = 7,
  parameter int RESET_LEN = 1048552
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  ffha_pkg::cell_cmd_t    cmd_i,
  input  wire  [CW-1:0]          wpos_i,
  input  wire  [AW-1:0]          push_start_i,
  input  wire  [AW-1:0]          push_len_i,
  input  wire                    push_free_i,
  input  wire  [AW-1:0]          next_start_i,
  input  wire  [AW-1:0]          next_len_i,
  input  wire                    next_free_i,
  output logic [AW-1:0]          start_o,
  output logic [AW-1:0]          len_o,
  output logic                   free_o
);

  logic [AW-1:0] start_q;
  logic [AW-1:0] len_q;
  logic          free_q;
  logic          here;

  // The pushed entry lands in this cell only when it is the queue's tail.
  assign here = cmd_i.push && (wpos_i == CW'(INDEX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      len_q   <= (INDEX == 0) ? AW'(RESET_LEN) : '0;
      free_q  <= (INDEX == 0);
    end else if (here) begin
      start_q <= push_start_i;
      len_q   <= push_len_i;
      free_q  <= push_free_i;
    end else if (cmd_i.pop) begin
      start_q <= next_start_i;
      len_q   <= next_len_i;
      free_q  <= next_free_i;
    end
  end

  assign start_o = start_q;
  assign len_o   = len_q;
  assign free_o  = free_q;

endmodule
`default_nettype wire

FILE: rtl/first_fit_heap_allocator.sv
`default_nettype none
// First-fit heap allocator. The managed region is held as an address-ordered
// queue of segment entries in a chain of cells; each pass streams the whole
// queue through the controller at the head, which pops one entry a cycle
// (pausing while a split-off rest is pushed) and pushes the (possibly changed
// or merged) entry back at the tail, so the table is rebuilt in order during
// each pass. An allocate first rounds the size up to whole pages by a
// multiplication with the reciprocal of the page size (states ST_DIV and
// ST_ROUND), then makes one pass, pushing the split-off rest when the chosen
// segment is split, and ends with a closing step. A free makes a search pass,
// then a pass that marks the segment free and merges runs of free neighbours;
// an unknown address ends after the search pass, and a free of address zero
// is answered without a pass. A request is accepted when start_i is high
// and busy_o is low; its result appears for exactly one cycle with done_o
// high and must be taken in that cycle, as the receiver cannot stall the
// block. A new request may be accepted in that same cycle. The user must
// write the region base through the APB port only while the block is idle;
// the block itself does not enforce this.
module first_fit_heap_allocator #(
  parameter int MEM_BYTES    = 1048576,
  parameter int PAGE_BYTES   = 512,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_SEGMENTS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         func_i,
  input  wire  [20:0] request_size_i,
  input  wire  [47:0] free_address_i,
  output logic        done_o,
  output logic [47:0] block_address_o,
  output logic [1:0]  status_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int NW = 22;
  localparam int SW = 21;
  localparam int PL = $clog2(PAGE_BYTES);
  localparam int RS = SW + PL;
  localparam int MW = SW + 2;
  localparam int PW = SW + MW;
  localparam longint RECIP_L = ((longint'(1) << RS) + longint'(PAGE_BYTES) - longint'(1))
                               / longint'(PAGE_BYTES);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [46:0] BASE_RESET = 47'h50000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ROUND, ST_ALLOC, ST_FIND, ST_MERGE
  } state_e;

  state_e             state_q;
  logic [46:0]        base_q;
  logic [20:0]        size_q;
  logic [47:0]        addr_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      rem_q;
  logic               found_q;
  logic               room_q;
  logic [SW-1:0]      quot_q;
  logic [NW-1:0]      need_q;
  logic [47:0]        res_q;
  logic               pend_q;
  logic [AW-1:0]      pend_start_q;
  logic [AW-1:0]      pend_len_q;
  logic               acc_v_q;
  logic [AW-1:0]      acc_start_q;
  logic [AW-1:0]      acc_len_q;
  logic               acc_free_q;
  logic               done_q;
  logic [47:0]        baddr_q;
  logic [1:0]         status_q;

  // Cell chain wiring.
  logic [AW-1:0] c_start [MAX_SEGMENTS+1];
  logic [AW-1:0] c_len   [MAX_SEGMENTS+1];
  logic          c_free  [MAX_SEGMENTS+1];

  ffha_pkg::cell_cmd_t cmd;
  logic [CW-1:0]       wpos;
  logic [AW-1:0]       push_start;
  logic [AW-1:0]       push_len;
  logic                push_free;

  logic [AW-1:0] head_start;
  logic [AW-1:0] head_len;
  logic          head_free;
  logic          fit;
  logic          split;
  logic          match;
  logic          merge_free;
  logic [PW-1:0] prod;
  logic [NW-1:0] down;
  logic          cfg_wr;

  assign c_start[MAX_SEGMENTS] = '0;
  assign c_len[MAX_SEGMENTS]   = '0;
  assign c_free[MAX_SEGMENTS]  = 1'b0;

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    ffha_cell #(
      .INDEX    (g),
      .AW       (AW),
      .CW       (CW),
      .RESET_LEN(MEM_BYTES - HEADER_BYTES)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .wpos_i      (wpos),
      .push_start_i(push_start),
      .push_len_i  (push_len),
      .push_free_i (push_free),
      .next_start_i(c_start[g+1]),
      .next_len_i  (c_len[g+1]),
      .next_free_i (c_free[g+1]),
      .start_o     (c_start[g]),
      .len_o       (c_len[g]),
      .free_o      (c_free[g])
    );
  end

  assign head_start = c_start[0];
  assign head_len   = c_len[0];
  assign head_free  = c_free[0];

  // A free segment fits when its payload covers the rounded size; it is split
  // when the rest still holds a header and the table has room for one more.
  assign fit   = head_free && (NW'(head_len) >= need_q);
  assign split = fit && ((NW+1)'(head_len) >= (NW+1)'(need_q) + (NW+1)'(HEADER_BYTES))
                 && room_q;
  assign match = (48'(base_q) + 48'(head_start) + 48'(HEADER_BYTES)) == addr_q;
  assign merge_free = head_free || match;

  // The number of whole pages in the size comes from a multiplication by the
  // rounded-up reciprocal of the page size, which is exact for every 21-bit
  // size. The size rounded down to whole pages then tells whether a partial
  // page remains.
  assign prod = PW'(size_q) * PW'(RECIP);
  assign down = NW'(quot_q) * NW'(PAGE_BYTES);

  always_comb begin
    cmd        = '0;
    push_start = head_start;
    push_len   = head_len;
    push_free  = head_free;
    case (state_q)
      ST_ALLOC: begin
        if (pend_q) begin
          cmd.push   = 1'b1;
          push_start = pend_start_q;
          push_len   = pend_len_q;
          push_free  = 1'b1;
        end else if (rem_q != '0) begin
          cmd.pop  = 1'b1;
          cmd.push = 1'b1;
          if (!found_q && fit) begin
            push_len  = split ? AW'(need_q) : head_len;
            push_free = 1'b0;
          end
        end
      end
      ST_FIND: begin
        if (rem_q != '0) begin
          cmd.pop  = 1'b1;
          cmd.push = 1'b1;
        end
      end
      ST_MERGE: begin
        push_start = acc_start_q;
        push_len   = acc_len_q;
        push_free  = acc_free_q;
        if (rem_q != '0) begin
          cmd.pop  = 1'b1;
          cmd.push = acc_v_q && !(acc_free_q && merge_free);
        end else begin
          cmd.push = acc_v_q;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign wpos = cnt_q - CW'(cmd.pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= CW'(1);
      rem_q    <= '0;
      found_q  <= 1'b0;
      room_q   <= 1'b0;
      pend_q   <= 1'b0;
      acc_v_q  <= 1'b0;
      done_q   <= 1'b0;
      baddr_q  <= '0;
      status_q <= ffha_pkg::STATUS_OK;
    end else begin
      done_q <= 1'b0;
      cnt_q  <= cnt_q + CW'(cmd.push) - CW'(cmd.pop);
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            size_q  <= request_size_i;
            addr_q  <= free_address_i;
            rem_q   <= cnt_q;
            found_q <= 1'b0;
            room_q  <= cnt_q < CW'(MAX_SEGMENTS);
            pend_q  <= 1'b0;
            acc_v_q <= 1'b0;
            if (func_i == ffha_pkg::FUNC_ALLOC) begin
              state_q <= ST_DIV;
            end else if (free_address_i == '0) begin
              done_q   <= 1'b1;
              baddr_q  <= '0;
              status_q <= ffha_pkg::STATUS_OK;
            end else begin
              state_q <= ST_FIND;
            end
          end
        end
        ST_DIV: begin
          quot_q  <= SW'(prod >> RS);
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          need_q  <= down + ((down != NW'(size_q)) ? NW'(PAGE_BYTES) : '0);
          state_q <= ST_ALLOC;
        end
        ST_ALLOC: begin
          if (pend_q) begin
            pend_q <= 1'b0;
          end else if (rem_q != '0) begin
            rem_q <= rem_q - CW'(1);
            if (!found_q && fit) begin
              found_q      <= 1'b1;
              res_q        <= 48'(base_q) + 48'(head_start) + 48'(HEADER_BYTES);
              pend_q       <= split;
              pend_start_q <= AW'(NW'(head_start) + NW'(HEADER_BYTES) + need_q);
              pend_len_q   <= AW'(NW'(head_len) - need_q - NW'(HEADER_BYTES));
            end
          end else begin
            done_q   <= 1'b1;
            baddr_q  <= found_q ? res_q : '0;
            status_q <= found_q ? ffha_pkg::STATUS_OK : ffha_pkg::STATUS_NOSPACE;
            state_q  <= ST_IDLE;
          end
        end
        ST_FIND: begin
          if (rem_q != '0) begin
            rem_q <= rem_q - CW'(1);
            if (match) begin
              found_q <= 1'b1;
            end
          end else if (!found_q) begin
            done_q   <= 1'b1;
            baddr_q  <= '0;
            status_q <= ffha_pkg::STATUS_UNKNOWN;
            state_q  <= ST_IDLE;
          end else begin
            rem_q   <= cnt_q;
            state_q <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (rem_q != '0) begin
            rem_q   <= rem_q - CW'(1);
            acc_v_q <= 1'b1;
            if (acc_v_q && acc_free_q && merge_free) begin
              acc_len_q <= AW'(acc_len_q + AW'(HEADER_BYTES) + head_len);
            end else begin
              acc_start_q <= head_start;
              acc_len_q   <= head_len;
              acc_free_q  <= merge_free;
            end
          end else begin
            acc_v_q  <= 1'b0;
            done_q   <= 1'b1;
            baddr_q  <= '0;
            status_q <= ffha_pkg::STATUS_OK;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Configuration: the region base is the only register, at byte address 0.
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_wr && !paddr[3]) begin
      base_q <= pwdata[46:0];
    end
  end

  assign prdata          = paddr[3] ? '0 : {17'b0, base_q};
  assign pready          = 1'b1;
  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign block_address_o = baddr_q;
  assign status_o        = status_q;

endmodule
`default_nettype wire

FILE: rtl/ffha_checker.sv
`default_nettype none
module ffha_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start_i,
  input wire        busy_o,
  input wire        done_o,
  input wire [47:0] block_address_o,
  input wire [1:0]  status_o
);

  // A result is only given once the block has gone back to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  // A failed request never reports an address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ffha_pkg::STATUS_OK) |-> block_address_o == '0)
    else $error("address on failure");

  // The block only becomes busy after a request transfer.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i)) else $error("busy without request");

  // Status never carries the unused code.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ffha_pkg::STATUS_OK || status_o == ffha_pkg::STATUS_NOSPACE ||
                status_o == ffha_pkg::STATUS_UNKNOWN)) else $error("bad status");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .block_address_o(block_address_o),
  .status_o       (status_o)
);
`default_nettype wire
